// ===== rtl/gfc_pkg.sv =====
// ----------------------------------------------------------------------------
// gfc_pkg
// shared constants, codes and types of the polygon geofence checker
// ----------------------------------------------------------------------------
package gfc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // wide arithmetic widths of the distance path
    localparam int NUM_W  = 124;
    localparam int DEN_W  = 62;
    localparam int QUO_W  = 64;
    localparam int ROOT_W = 32;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_POS    = 2'd2;
    localparam logic [1:0] CMD_CHECK  = 2'd3;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_SAFE = 2'd1;
    localparam logic [1:0] ST_WARN = 2'd2;
    localparam logic [1:0] ST_VIOL = 2'd3;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_APPROACH = 2'd1;
    localparam logic [1:0] EV_VIOL     = 2'd2;
    localparam logic [1:0] EV_BACK     = 2'd3;

    localparam logic [1:0] REG_WARN = 2'd0;
    localparam logic [1:0] REG_STOP = 2'd1;

    localparam logic [30:0] WARN_RESET = 31'd196608;
    localparam logic [30:0] STOP_RESET = 31'd32768;
    localparam logic [30:0] MAG_MAX    = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREV_RD,
        S_PREV_CAP,
        S_CUR_RD,
        S_CUR_CAP,
        S_MUL,
        S_CLASS,
        S_DIV,
        S_SQRT,
        S_FIN
    } fsm_t;

    // handshake between the sequencer and an iterative unit
    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

endpackage

// ===== rtl/polygon_geofence_checker_top.sv =====
// ----------------------------------------------------------------------------
// polygon_geofence_checker_top
// polygon fence check: ray cast for inside, nearest edge distance, margins
// ----------------------------------------------------------------------------
// Commands arrive one beat at a time on the input channel. Write vertex, commit
// and update position produce no result. A run check beat produces exactly one
// result beat. Without a fence or a position it goes straight to the result.
// Otherwise the vertex ram is walked one edge at a time: each edge is read,
// multiplied out and classified, and an edge whose nearest point lies inside the
// segment runs the restoring divider ahead of the square root. The shared 33x33
// multiplier issues one product per cycle over a 17-step schedule for each edge.
// The input channel stalls while a check runs; the result sits in an output
// register so new commands are taken while it waits. The user must write the
// margin registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module polygon_geofence_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [5:0]  vertex_index,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic [6:0]  vertex_count,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  fence_state,
    output logic signed [31:0] signed_margin,
    output logic        stop_request,
    output logic [1:0]  event_code,
    // margin registers
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import gfc_pkg::*;

    // floor((a - b) / 4) on the full 33-bit difference
    function automatic logic signed [30:0] coarse(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32:2];
    endfunction

    fsm_t state_reg, state_next;

    // fence and position state
    logic [CNT_W-1:0]   fence_size_reg;
    logic               fence_valid_reg;
    logic signed [31:0] robot_x_reg, robot_y_reg;
    logic               pos_valid_reg;
    logic [1:0]         last_reg;
    logic [30:0]        warn_reg, stop_reg;

    // per-check working state
    logic [CNT_W-1:0]   idx_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic [4:0]         step_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] len_reg, dot_reg, w2_reg, v2_reg, cr_reg;
    logic signed [65:0] lhs_reg, rhs_reg;
    logic [NUM_W-1:0]   num_reg;
    logic               inside_reg;
    logic [ROOT_W-1:0]  dmin_reg;
    logic               unchk_reg;

    // result register
    logic               out_valid_reg;
    logic [1:0]         fence_state_reg;
    logic signed [31:0] margin_reg;
    logic               stop_reg_out;
    logic [1:0]         event_reg;

    // ram
    logic               ram_we;
    logic [VIDX_W-1:0]  ram_raddr;
    logic [63:0]        ram_rdata;

    // handshakes
    logic               in_fire;
    logic               chk_ok;
    logic               out_load;

    // arithmetic
    logic signed [30:0] ex, ey, wx, wy, vx, vy;
    logic signed [32:0] op_a, op_b;
    logic [62:0]        cr_mag;
    logic [30:0]        cr_hi, cr_lo;
    logic               use_div, straddle, hit;

    // iterative units
    logic               div_start, div_done;
    logic [QUO_W-1:0]   div_quot;
    unit_ctl_t          sq_ctl_in, sq_ctl_out;
    logic [QUO_W-1:0]   sq_op;
    logic [ROOT_W-1:0]  sq_root;

    // result classification
    logic [33:0]        d4;
    logic [30:0]        mag;
    logic [1:0]         st_new, ev_new;

    assign in_fire = in_valid && !in_stall;
    assign chk_ok  = fence_valid_reg && pos_valid_reg;
    assign ram_we  = in_fire && (command == CMD_WRITE) && (32'(vertex_index) < MAX_VERTICES);

    gfc_ram #(
        .WIDTH (64),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (VIDX_W'(vertex_index)),
        .wdata ({x_coord, y_coord}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // edge A is the previous vertex, edge B the current one
    assign ex = coarse(cur_x_reg, prev_x_reg);
    assign ey = coarse(cur_y_reg, prev_y_reg);
    assign wx = coarse(robot_x_reg, prev_x_reg);
    assign wy = coarse(robot_y_reg, prev_y_reg);
    assign vx = coarse(robot_x_reg, cur_x_reg);
    assign vy = coarse(robot_y_reg, cur_y_reg);

    assign cr_mag = cr_reg[63] ? 63'(-cr_reg) : cr_reg[62:0];
    assign cr_hi  = cr_mag[61:31];
    assign cr_lo  = cr_mag[30:0];

    // multiplier schedule, each product is registered in prod_reg before it is consumed
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            5'd0:
            begin
                op_a = 33'(ex); op_b = 33'(ex);
            end
            5'd1:
            begin
                op_a = 33'(ey); op_b = 33'(ey);
            end
            5'd2:
            begin
                op_a = 33'(wx); op_b = 33'(ex);
            end
            5'd3:
            begin
                op_a = 33'(wy); op_b = 33'(ey);
            end
            5'd4:
            begin
                op_a = 33'(wx); op_b = 33'(wx);
            end
            5'd5:
            begin
                op_a = 33'(wy); op_b = 33'(wy);
            end
            5'd6:
            begin
                op_a = 33'(vx); op_b = 33'(vx);
            end
            5'd7:
            begin
                op_a = 33'(vy); op_b = 33'(vy);
            end
            5'd8:
            begin
                op_a = 33'(robot_x_reg) - 33'(cur_x_reg);
                op_b = 33'(prev_y_reg) - 33'(cur_y_reg);
            end
            5'd9:
            begin
                op_a = 33'(prev_x_reg) - 33'(cur_x_reg);
                op_b = 33'(robot_y_reg) - 33'(cur_y_reg);
            end
            5'd10:
            begin
                op_a = 33'(wx); op_b = 33'(ey);
            end
            5'd11:
            begin
                op_a = 33'(wy); op_b = 33'(ex);
            end
            // step 12 is a bubble while the cross product settles
            5'd13:
            begin
                op_a = {2'b00, cr_hi}; op_b = {2'b00, cr_hi};
            end
            5'd14:
            begin
                op_a = {2'b00, cr_hi}; op_b = {2'b00, cr_lo};
            end
            5'd15:
            begin
                op_a = {2'b00, cr_lo}; op_b = {2'b00, cr_lo};
            end
            default:
            begin
                op_a = '0; op_b = '0;
            end
        endcase
    end

    // edge classification
    assign straddle = (cur_y_reg > robot_y_reg) != (prev_y_reg > robot_y_reg);
    assign hit      = (prev_y_reg > cur_y_reg) ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg);
    assign use_div  = !((len_reg == 64'sd0) || (dot_reg <= 64'sd0) || (dot_reg >= len_reg));

    gfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (DEN_W'(len_reg)),
        .done  (div_done),
        .quot  (div_quot)
    );

    gfc_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (sq_ctl_in),
        .op      (sq_op),
        .ctl_out (sq_ctl_out),
        .root    (sq_root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (command == CMD_CHECK))
                begin
                    state_next = chk_ok ? S_PREV_RD : S_FIN;
                end
            end
            S_PREV_RD:  state_next = S_PREV_CAP;
            S_PREV_CAP: state_next = S_CUR_RD;
            S_CUR_RD:   state_next = S_CUR_CAP;
            S_CUR_CAP:  state_next = S_MUL;
            S_MUL:
            begin
                if (step_reg == 5'd16)
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:    state_next = use_div ? S_DIV : S_SQRT;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_ctl_out.done)
                begin
                    state_next = (idx_reg + CNT_W'(1) == fence_size_reg) ? S_FIN : S_CUR_RD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall        = 1'b1;
        ram_raddr       = VIDX_W'(idx_reg);
        div_start       = 1'b0;
        sq_ctl_in.start = 1'b0;
        sq_ctl_in.done  = 1'b0;
        sq_op           = QUO_W'(w2_reg);
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:    in_stall = 1'b0;
            S_PREV_RD: ram_raddr = VIDX_W'(fence_size_reg - CNT_W'(1));
            S_CLASS:
            begin
                div_start       = use_div;
                sq_ctl_in.start = !use_div;
                sq_op = (len_reg == 64'sd0 || dot_reg <= 64'sd0) ?
                        QUO_W'(w2_reg) : QUO_W'(v2_reg);
            end
            S_DIV:
            begin
                sq_ctl_in.start = div_done;
                sq_op           = div_quot;
            end
            S_FIN:     out_load = !out_valid_reg || !out_stall;
            default:   in_stall = 1'b1;
        endcase
    end

    // classification of the finished check
    assign d4  = {dmin_reg, 2'b00};
    assign mag = (d4 > 34'(MAG_MAX)) ? MAG_MAX : d4[30:0];

    always_comb
    begin
        if (!inside_reg || mag < stop_reg)
        begin
            st_new = ST_VIOL;
        end
        else if (mag < warn_reg)
        begin
            st_new = ST_WARN;
        end
        else
        begin
            st_new = ST_SAFE;
        end

        ev_new = EV_NONE;
        if (st_new != last_reg)
        begin
            case (st_new)
                ST_WARN: ev_new = EV_APPROACH;
                ST_VIOL: ev_new = EV_VIOL;
                ST_SAFE: ev_new = (last_reg == ST_VIOL || last_reg == ST_WARN) ?
                                  EV_BACK : EV_NONE;
                default: ev_new = EV_NONE;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fence_size_reg  <= '0;
            fence_valid_reg <= 1'b0;
            robot_x_reg     <= '0;
            robot_y_reg     <= '0;
            pos_valid_reg   <= 1'b0;
            last_reg        <= ST_NONE;
            warn_reg        <= WARN_RESET;
            stop_reg        <= STOP_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && cfg_index == REG_WARN)
            begin
                warn_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_STOP)
            begin
                stop_reg <= cfg_data;
            end

            if (in_fire && command == CMD_COMMIT &&
                vertex_count >= 7'd3 && 32'(vertex_count) <= MAX_VERTICES)
            begin
                fence_size_reg  <= CNT_W'(vertex_count);
                fence_valid_reg <= 1'b1;
            end
            if (in_fire && command == CMD_POS)
            begin
                robot_x_reg   <= x_coord;
                robot_y_reg   <= y_coord;
                pos_valid_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (!unchk_reg)
                begin
                    last_reg <= st_new;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_fire && command == CMD_CHECK)
        begin
            unchk_reg  <= !chk_ok;
            idx_reg    <= '0;
            inside_reg <= 1'b0;
            dmin_reg   <= '1;
        end

        if (state_reg == S_PREV_CAP)
        begin
            prev_x_reg <= ram_rdata[63:32];
            prev_y_reg <= ram_rdata[31:0];
        end

        if (state_reg == S_CUR_CAP)
        begin
            cur_x_reg <= ram_rdata[63:32];
            cur_y_reg <= ram_rdata[31:0];
            step_reg  <= '0;
        end

        if (state_reg == S_MUL)
        begin
            prod_reg <= op_a * op_b;
            step_reg <= step_reg + 5'd1;
            case (step_reg)
                5'd1:  len_reg <= prod_reg[63:0];
                5'd2:  len_reg <= len_reg + prod_reg[63:0];
                5'd3:  dot_reg <= prod_reg[63:0];
                5'd4:  dot_reg <= dot_reg + prod_reg[63:0];
                5'd5:  w2_reg  <= prod_reg[63:0];
                5'd6:  w2_reg  <= w2_reg + prod_reg[63:0];
                5'd7:  v2_reg  <= prod_reg[63:0];
                5'd8:  v2_reg  <= v2_reg + prod_reg[63:0];
                5'd9:  lhs_reg <= prod_reg;
                5'd10: rhs_reg <= prod_reg;
                5'd11: cr_reg  <= prod_reg[63:0];
                5'd12: cr_reg  <= cr_reg - prod_reg[63:0];
                5'd14: num_reg <= {prod_reg[61:0], 62'd0};
                5'd15: num_reg <= num_reg + {30'd0, prod_reg[61:0], 32'd0};
                5'd16: num_reg <= num_reg + NUM_W'(prod_reg[61:0]);
                default: num_reg <= num_reg;
            endcase
        end

        if (state_reg == S_CLASS && straddle && hit)
        begin
            inside_reg <= !inside_reg;
        end

        if (state_reg == S_SQRT && sq_ctl_out.done)
        begin
            if (sq_root < dmin_reg)
            begin
                dmin_reg <= sq_root;
            end
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            idx_reg    <= idx_reg + CNT_W'(1);
        end

        if (out_load)
        begin
            if (unchk_reg)
            begin
                fence_state_reg <= fence_valid_reg ? ST_SAFE : ST_NONE;
                margin_reg      <= '0;
                stop_reg_out    <= 1'b0;
                event_reg       <= EV_NONE;
            end
            else
            begin
                fence_state_reg <= st_new;
                margin_reg      <= inside_reg ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
                stop_reg_out    <= st_new == ST_VIOL;
                event_reg       <= ev_new;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign fence_state   = fence_state_reg;
    assign signed_margin = margin_reg;
    assign stop_request  = stop_reg_out;
    assign event_code    = event_reg;

endmodule

// ===== rtl/gfc_ram.sv =====
// ----------------------------------------------------------------------------
// gfc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gfc_div.sv =====
// ----------------------------------------------------------------------------
// gfc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gfc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gfc_pkg::NUM_W-1:0] num,
    input  logic [gfc_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [gfc_pkg::QUO_W-1:0] quot
);
    import gfc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [QUO_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     low_reg;
    logic [QUO_W-1:0]     quot_reg;
    logic [QUO_W-1:0]     trial;
    logic                 fits;

    // quotient is known to stay below 2^64, so the high part starts as remainder
    assign trial = {rem_reg[QUO_W-2:0], low_reg[QUO_W-1]};
    assign fits  = trial >= QUO_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= QUO_W'(num[NUM_W-1:QUO_W]);
            low_reg <= num[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial - QUO_W'(den) : trial;
            low_reg  <= {low_reg[QUO_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/gfc_sqrt.sv =====
// ----------------------------------------------------------------------------
// gfc_sqrt
// integer square root, two operand bits per cycle
// ----------------------------------------------------------------------------
module gfc_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gfc_pkg::unit_ctl_t         ctl_in,
    input  logic [gfc_pkg::QUO_W-1:0]  op,
    output gfc_pkg::unit_ctl_t         ctl_out,
    output logic [gfc_pkg::ROOT_W-1:0] root
);
    import gfc_pkg::*;

    localparam int REM_W = ROOT_W + 4;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [QUO_W-1:0]  op_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  r_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign r_shift = {rem_reg[REM_W-3:0], op_reg[QUO_W-1:QUO_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = r_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            op_reg   <= op;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[QUO_W-3:0], 2'b00};
            rem_reg  <= fits ? r_shift - trial : r_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign ctl_out.start = busy_reg;
    assign ctl_out.done  = done_reg;
    assign root          = root_reg;

endmodule

// ===== rtl/gfc_checker.sv =====
// ----------------------------------------------------------------------------
// gfc_checker
// port level checks of the polygon geofence checker
// ----------------------------------------------------------------------------
module gfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  command,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  fence_state,
    input logic signed [31:0] signed_margin,
    input logic        stop_request,
    input logic [1:0]  event_code
);
    import gfc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fence_state) &&
        $stable(signed_margin) && $stable(event_code))
        else $error("result beat changed under stall");

    // stop request goes with a violation only
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stop_request == (fence_state == ST_VIOL)))
        else $error("stop request does not match state");

    // no fence gives an empty result
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fence_state == ST_NONE |->
        signed_margin == 32'sd0 && event_code == EV_NONE)
        else $error("no fence result not empty");

    // a check takes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_CHECK |=> in_stall)
        else $error("check did not stall input");

endmodule

bind polygon_geofence_checker_top gfc_checker u_gfc_checker (.*);

// ===== tb/tb_polygon_geofence_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_geofence_checker_top
// self-checking bench for the polygon geofence checker
// ----------------------------------------------------------------------------
// A directed table walks the basic flow first: no fence, no position, ignored
// commits, safe, violation, back in safe, and full-scale vertices.
// After that the bench builds random fences and moves the robot around them,
// with some noise beats mixed in. Each accepted beat goes through a bit-exact
// predictor, and each result beat is checked field by field against the
// oldest expected report. Both channels idle and stall at random, and the
// margin registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_polygon_geofence_checker_top;

    import gfc_pkg::*;

    localparam int  TOTAL_BEATS = 580;
    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  Q1M         = 65536;
    // register indexes that map to nothing
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [1:0]        state;
        logic signed [31:0] margin;
        logic              stop;
        logic [1:0]        ev;
    } fence_report_t;

    typedef struct {
        logic [1:0]        cmd;
        logic [5:0]        idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [6:0]        cnt;
        bit                typed;
        fence_report_t     rep;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        command;
    logic [5:0]        vertex_index;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [6:0]        vertex_count;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        fence_state;
    logic signed [31:0] signed_margin;
    logic              stop_request;
    logic [1:0]        event_code;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [30:0]       cfg_data;

    polygon_geofence_checker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .vertex_index  (vertex_index),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .vertex_count  (vertex_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fence_state   (fence_state),
        .signed_margin (signed_margin),
        .stop_request  (stop_request),
        .event_code    (event_code),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow of the block state, kept by the predictor
    logic signed [31:0] fence_x [MAX_VERTICES];
    logic signed [31:0] fence_y [MAX_VERTICES];
    bit                 slot_written [MAX_VERTICES];
    int                 fence_len;
    bit                 fence_ok;
    logic signed [31:0] robot_px;
    logic signed [31:0] robot_py;
    bit                 pos_ok;
    logic [1:0]         last_state;
    logic [30:0]        warn_lim;
    logic [30:0]        stop_lim;

    fence_report_t pending_reports[$];
    int            errors;
    int            beats_sent;
    int            checks_seen;
    int            state_hits [4];
    int            cycle_count;
    bit            calm;
    int            big_fences;
    real           fence_cx;
    real           fence_cy;
    real           fence_r;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports pending", cycle_count,
                     pending_reports.size());
            $display("tb_polygon_geofence_checker_top NOT OK");
            $finish;
        end
    end

    // result side back-pressure, off during the calm stretch
    always @(posedge clk)
    begin
        if (!rst_n || calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 32);
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor of the difference in quarter-lsb units
    function automatic logic signed [127:0] coarse_q(logic signed [127:0] a,
                                                      logic signed [127:0] b);
        return (a - b) >>> 2;
    endfunction

    // largest d below 2^31 with d*d*den <= num
    function automatic logic [127:0] root_of_ratio(logic [127:0] num, logic [127:0] den);
        logic [127:0] d;
        logic [127:0] c;
        d = '0;
        for (int b = 30; b >= 0; b--)
        begin
            c = d | (128'd1 << b);
            if (c * c * den <= num)
                d = c;
        end
        return d;
    endfunction

    // coarse distance from point p to segment a-b
    function automatic logic [127:0] edge_dist(logic signed [127:0] px, logic signed [127:0] py,
                                               logic signed [127:0] ax, logic signed [127:0] ay,
                                               logic signed [127:0] bx, logic signed [127:0] by);
        logic signed [127:0] ex, ey, wx, wy, vx, vy, len_sq, dot, cr;
        ex = coarse_q(bx, ax);
        ey = coarse_q(by, ay);
        wx = coarse_q(px, ax);
        wy = coarse_q(py, ay);
        len_sq = ex * ex + ey * ey;
        dot = wx * ex + wy * ey;
        if (len_sq == 0 || dot <= 0)
            return root_of_ratio($unsigned(wx * wx + wy * wy), 128'd1);
        if (dot >= len_sq)
        begin
            vx = coarse_q(px, bx);
            vy = coarse_q(py, by);
            return root_of_ratio($unsigned(vx * vx + vy * vy), 128'd1);
        end
        cr = wx * ey - wy * ex;
        if (cr < 0)
            cr = -cr;
        return root_of_ratio($unsigned(cr * cr), $unsigned(len_sq));
    endfunction

    task automatic apply_beat(input logic [1:0] cmd, input logic [5:0] idx,
                              input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic [6:0] cnt, output bit has,
                              output fence_report_t rep);
        logic signed [127:0] px, py, xi, yi, xj, yj, dy, lhs, rhs;
        logic [127:0] dmin, d;
        logic [31:0]  dq;
        bit           in_poly;
        int           j;
        has = 1'b0;
        rep = '{ST_NONE, 32'sd0, 1'b0, EV_NONE};
        case (cmd)
            CMD_WRITE:
            begin
                fence_x[idx] = x;
                fence_y[idx] = y;
                slot_written[idx] = 1'b1;
            end
            CMD_COMMIT:
            begin
                if (cnt >= 3 && cnt <= MAX_VERTICES)
                begin
                    fence_len = cnt;
                    fence_ok = 1'b1;
                end
            end
            CMD_POS:
            begin
                robot_px = x;
                robot_py = y;
                pos_ok = 1'b1;
            end
            default:
            begin
                has = 1'b1;
                if (!fence_ok || !pos_ok)
                    rep.state = fence_ok ? ST_SAFE : ST_NONE;
                else
                begin
                    px = robot_px;
                    py = robot_py;
                    in_poly = 1'b0;
                    dmin = '1;
                    j = fence_len - 1;
                    for (int i = 0; i < fence_len; i++)
                    begin
                        xi = fence_x[i];
                        yi = fence_y[i];
                        xj = fence_x[j];
                        yj = fence_y[j];
                        // crossing test by cross-multiplication
                        if ((yi > py) != (yj > py))
                        begin
                            dy = yj - yi;
                            lhs = (px - xi) * dy;
                            rhs = (xj - xi) * (py - yi);
                            if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                                in_poly = !in_poly;
                        end
                        d = edge_dist(px, py, xj, yj, xi, yi);
                        if (d < dmin)
                            dmin = d;
                        j = i;
                    end
                    d = dmin << 2;
                    if (d > MAG_MAX)
                        d = MAG_MAX;
                    if (!in_poly || d < stop_lim)
                        rep.state = ST_VIOL;
                    else if (d < warn_lim)
                        rep.state = ST_WARN;
                    else
                        rep.state = ST_SAFE;
                    if (rep.state != last_state)
                    begin
                        if (rep.state == ST_WARN)
                            rep.ev = EV_APPROACH;
                        else if (rep.state == ST_VIOL)
                            rep.ev = EV_VIOL;
                        else if (last_state == ST_VIOL || last_state == ST_WARN)
                            rep.ev = EV_BACK;
                        last_state = rep.state;
                    end
                    dq = d[31:0];
                    rep.margin = in_poly ? $signed(dq) : -$signed(dq);
                    rep.stop = (rep.state == ST_VIOL);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic send_beat(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic [6:0] cnt, input bit typed,
                             input fence_report_t typed_rep);
        bit has;
        fence_report_t rep;
        calm = (beats_sent >= 200 && beats_sent < 320);
        while (!calm && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        vertex_index <= idx;
        x_coord      <= x;
        y_coord      <= y;
        vertex_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // beat taken at this edge
        apply_beat(cmd, idx, x, y, cnt, has, rep);
        if (has)
            pending_reports.push_back(typed ? typed_rep : rep);
        beats_sent++;
    endtask

    // park the sender until every report is back and the block has settled
    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_margins(input logic [30:0] warn, input logic [30:0] stop,
                                 input logic [1:0] spare_idx, input logic [30:0] spare_data);
        cfg_write <= 1'b1;
        cfg_index <= REG_WARN;
        cfg_data  <= warn;
        @(posedge clk);
        cfg_index <= REG_STOP;
        cfg_data  <= stop;
        @(posedge clk);
        // unmapped index, must change nothing
        cfg_index <= spare_idx;
        cfg_data  <= spare_data;
        @(posedge clk);
        cfg_write <= 1'b0;
        warn_lim = warn;
        stop_lim = stop;
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // write slots 0..n-1 with a fresh polygon
    task automatic load_fence(input int n);
        fence_report_t none;
        int  style;
        real ang, rad;
        longint vx, vy;
        none = '{ST_NONE, 32'sd0, 1'b0, EV_NONE};
        style = $urandom_range(0, 9);
        if (style < 7)
        begin
            fence_r  = $urandom_range(2, 40) * 65536.0;
            fence_cx = ($itor($urandom_range(0, 2000)) - 1000.0) * 65536.0;
            fence_cy = ($itor($urandom_range(0, 2000)) - 1000.0) * 65536.0;
        end
        else
        begin
            // huge fences push the distance into saturation
            fence_r  = (style == 7) ? $urandom_range(500, 1000) * 1.0e6 : 1073741824.0;
            fence_cx = 0.0;
            fence_cy = 0.0;
        end
        for (int k = 0; k < n; k++)
        begin
            if (style >= 8)
            begin
                vx = $signed($urandom);
                vy = $signed($urandom);
            end
            else
            begin
                ang = 6.2831853 * (k + 0.4 * $urandom_range(0, 100) / 100.0) / n;
                rad = fence_r * (0.6 + 0.4 * $urandom_range(0, 100) / 100.0);
                vx  = $rtoi(fence_cx + rad * $cos(ang));
                vy  = $rtoi(fence_cy + rad * $sin(ang));
            end
            send_beat(CMD_WRITE, k[5:0], clamp32(vx), clamp32(vy), $urandom, 1'b0, none);
        end
    endtask

    // move the robot around, inside, near a corner, or anywhere
    task automatic place_robot(input int n);
        fence_report_t none;
        int     style, k;
        longint rx, ry;
        none = '{ST_NONE, 32'sd0, 1'b0, EV_NONE};
        style = $urandom_range(0, 9);
        if (style < 5)
        begin
            rx = $rtoi(fence_cx + fence_r * ($itor($urandom_range(0, 260)) - 130.0) / 100.0);
            ry = $rtoi(fence_cy + fence_r * ($itor($urandom_range(0, 260)) - 130.0) / 100.0);
        end
        else if (style < 8)
        begin
            k  = $urandom_range(0, n - 1);
            rx = longint'(fence_x[k]) + $urandom_range(0, 8 * Q1M) - 4 * Q1M;
            ry = longint'(fence_y[k]) + $urandom_range(0, 8 * Q1M) - 4 * Q1M;
        end
        else
        begin
            rx = $signed($urandom);
            ry = $signed($urandom);
        end
        send_beat(CMD_POS, $urandom, clamp32(rx), clamp32(ry), $urandom, 1'b0, none);
    endtask

    function automatic stim_row_t dir_row(logic [1:0] cmd, logic [5:0] idx,
                                          logic signed [31:0] x, logic signed [31:0] y,
                                          logic [6:0] cnt, bit typed, logic [1:0] st);
        stim_row_t r;
        r.cmd = cmd;
        r.idx = idx;
        r.x = x;
        r.y = y;
        r.cnt = cnt;
        r.typed = typed;
        r.rep = '{st, 32'sd0, 1'b0, EV_NONE};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        fence_report_t exp_rep;
        if (rst_n && out_valid && !out_stall)
        begin
            checks_seen++;
            state_hits[fence_state]++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, state %0d margin %0d", $time,
                         fence_state, signed_margin);
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                if (fence_state !== exp_rep.state)
                begin
                    errors++;
                    $display("%0t: fence_state expected %0d actual %0d", $time,
                             exp_rep.state, fence_state);
                end
                if (signed_margin !== exp_rep.margin)
                begin
                    errors++;
                    $display("%0t: signed_margin expected %0d actual %0d", $time,
                             exp_rep.margin, signed_margin);
                end
                if (stop_request !== exp_rep.stop)
                begin
                    errors++;
                    $display("%0t: stop_request expected %0d actual %0d", $time,
                             exp_rep.stop, stop_request);
                end
                if (event_code !== exp_rep.ev)
                begin
                    errors++;
                    $display("%0t: event_code expected %0d actual %0d", $time,
                             exp_rep.ev, event_code);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t     rows[$];
        fence_report_t none;
        int            n, contig;
        logic [5:0]    slot;

        none = '{ST_NONE, 32'sd0, 1'b0, EV_NONE};
        errors = 0;
        beats_sent = 0;
        checks_seen = 0;
        cycle_count = 0;
        calm = 1'b0;
        big_fences = 0;
        foreach (state_hits[s])
            state_hits[s] = 0;
        foreach (slot_written[s])
        begin
            slot_written[s] = 1'b0;
            fence_x[s] = '0;
            fence_y[s] = '0;
        end
        fence_len = 0;
        fence_ok = 1'b0;
        robot_px = '0;
        robot_py = '0;
        pos_ok = 1'b0;
        last_state = ST_NONE;
        warn_lim = WARN_RESET;
        stop_lim = STOP_RESET;
        fence_cx = 0.0;
        fence_cy = 0.0;
        fence_r = 10.0 * Q1M;

        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_WRITE;
        vertex_index = '0;
        x_coord = '0;
        y_coord = '0;
        vertex_count = '0;
        cfg_write = 1'b0;
        cfg_index = REG_WARN;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: typed rows carry their report, the rest are predicted
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 1, ST_NONE));     // nothing set up
        rows.push_back(dir_row(CMD_WRITE,  0, -10 * Q1M, -10 * Q1M, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_WRITE,  1,  10 * Q1M, -10 * Q1M, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_WRITE,  2,  10 * Q1M,  10 * Q1M, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_WRITE,  3, -10 * Q1M,  10 * Q1M, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_COMMIT, 0, 0, 0, 2, 0, ST_NONE));     // too short
        rows.push_back(dir_row(CMD_COMMIT, 0, 0, 0, 65, 0, ST_NONE));    // too long
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 1, ST_NONE));     // still no fence
        rows.push_back(dir_row(CMD_COMMIT, 0, 0, 0, 4, 0, ST_NONE));
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 1, ST_SAFE));     // fence, no position
        rows.push_back(dir_row(CMD_POS,    0, 0, 0, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_POS,    0, 642252, 0, 0, 0, ST_NONE)); // near the wall
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_POS,    0, 20 * Q1M, 0, 0, 0, ST_NONE)); // outside
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_POS,    0, 0, 0, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 0, ST_NONE));     // back in safe
        rows.push_back(dir_row(CMD_WRITE, 63, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_WRITE,  0, 32'sh8000_0000, 32'sh8000_0000, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_WRITE,  1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_WRITE,  2, 0, 32'sh7FFF_FFFF, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_COMMIT, 0, 0, 0, 3, 0, ST_NONE));
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 0, ST_NONE));     // inside the full-scale fence
        rows.push_back(dir_row(CMD_POS,    0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, ST_NONE));
        rows.push_back(dir_row(CMD_CHECK,  0, 0, 0, 0, 0, ST_NONE));     // far outside
        rows.push_back(dir_row(CMD_COMMIT, 63, -1, -1, 127, 0, ST_NONE)); // ignored, all ones
        foreach (rows[r])
            send_beat(rows[r].cmd, rows[r].idx, rows[r].x, rows[r].y, rows[r].cnt,
                      rows[r].typed, rows[r].rep);

        // random phase: fences built and probed, with some noise in between
        while (beats_sent < TOTAL_BEATS)
        begin
            if (beats_sent >= 145 && warn_lim == WARN_RESET && stop_lim == STOP_RESET)
            begin
                // everything short of a saturated margin becomes a violation
                drain_reports();
                write_margins(MAG_MAX, MAG_MAX, REG_SPARE_A, '0);
            end
            else if (beats_sent >= 290 && stop_lim == MAG_MAX)
            begin
                // only leaving the fence is a violation
                drain_reports();
                write_margins('0, '0, REG_SPARE_B, MAG_MAX);
            end
            else if (beats_sent >= 435 && warn_lim == 0)
            begin
                drain_reports();
                n = $urandom_range(Q1M, 10 * Q1M);
                write_margins(n, $urandom_range(0, n), REG_SPARE_A, $urandom);
            end

            if ($urandom_range(0, 3) != 0)
            begin
                // well-formed: load, commit, then one to four probes
                if (big_fences < 3 && $urandom_range(0, 25) == 0)
                begin
                    n = MAX_VERTICES;
                    big_fences++;
                end
                else
                    n = $urandom_range(3, 8);
                load_fence(n);
                send_beat(CMD_COMMIT, $urandom, $urandom, $urandom, n, 1'b0, none);
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        // live edit of a fence in use
                        slot = $urandom_range(0, n - 1);
                        send_beat(CMD_WRITE, slot,
                                  fence_x[slot] + $signed($urandom_range(0, 4 * Q1M)) - 2 * Q1M,
                                  fence_y[slot], $urandom, 1'b0, none);
                    end
                    place_robot(n);
                    send_beat(CMD_CHECK, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
                end
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: send_beat(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
                    1: send_beat(CMD_COMMIT, $urandom, $urandom, $urandom,
                                 $urandom_range(0, 1) ? $urandom_range(0, 2)
                                                      : $urandom_range(65, 127),
                                 1'b0, none);
                    2: send_beat(CMD_POS, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
                    3: send_beat(CMD_CHECK, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
                    default:
                    begin
                        contig = 0;
                        while (contig < MAX_VERTICES && slot_written[contig])
                            contig++;
                        if (contig >= 3)
                            send_beat(CMD_COMMIT, $urandom, $urandom, $urandom,
                                      $urandom_range(3, contig), 1'b0, none);
                    end
                endcase
            end
        end

        // let the last checks come out, then a short settle
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d beats, checked %0d results", beats_sent, checks_seen);
        $display("results by state: none %0d, safe %0d, warning %0d, violation %0d",
                 state_hits[0], state_hits[1], state_hits[2], state_hits[3]);
        if (errors == 0 && pending_reports.size() == 0)
            $display("tb_polygon_geofence_checker_top OK");
        else
            $display("tb_polygon_geofence_checker_top NOT OK");
        $finish;
    end

endmodule
